FILE: sv/rff_pkg.sv
// rff_pkg: shared types and codes for the range-fit free-list allocator.
// No dependencies.
`timescale 1ns / 1ps
package rff_pkg;
  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } seg_t;
endpackage

FILE: sv/range_fit_free_list_allocator_core.sv
// range_fit_free_list_allocator_core: top level of the free-list allocator.
// Depends on rff_pkg and rff_ram.
`timescale 1ns / 1ps
//
//  channel | valid / ready     | payload
//  --------+-------------------+-------------------------------------------------
//  in      | in_valid/in_ready | command_i req_min_i req_max_i free_offset_i ...
//  out     | out_valid/out_rdy | status_o grant_offset_o grant_size_o live_alloc
//  cfg     | cfg_valid/cfg_rdy | cfg_data_i (heap_size)
//
// One transaction at a time. The segment table sits in one RAM (start,length)
// with a registered read. Alloc scans the table, then shifts entries down on
// removal; free scans to the insert point and shifts up on insert, or down when
// it joins both neighbors. Reset writes the single segment [0, heap_size) with
// heap_size = 65536.
// The result is held in an output register; a stalled output holds the block.
module range_fit_free_list_allocator_core
  import rff_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] req_min_i,
  input  logic [31:0] req_max_i,
  input  logic [31:0] free_offset_i,
  input  logic [31:0] free_size_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] grant_offset_o,
  output logic [31:0] grant_size_o,
  output logic [31:0] live_allocations_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);
  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_SEGMENTS);

  typedef enum logic [3:0] {
    S_BOOT, S_IDLE, S_INIT, S_ASCAN, S_AFIN, S_FSCAN, S_FFIN,
    S_SHDN, S_SHUP, S_SHUPW, S_WR2, S_DONE
  } state_e;

  state_e      state_q;
  logic [31:0] heap_q;
  logic [CW-1:0] cnt_q;
  logic [31:0] alloc_q;
  logic [1:0]  cmd_q;
  logic [31:0] a_q, b_q;          // min/max or offset/size
  logic [CW-1:0] idx_q;           // read index issued
  logic        rv_q;              // read data valid this cycle
  logic [CW-1:0] ridx_q;          // index of data on rdata
  logic [32:0] best_q;            // best size, signed-ish 33 bit (min-1 may be -1)
  logic        found_q;
  logic [AW-1:0] bidx_q;
  seg_t        bseg_q;            // best seg / next seg
  seg_t        pseg_q;            // previous seg for free
  logic        pvalid_q;
  logic [CW-1:0] pos_q;
  logic [CW-1:0] sh_q;            // shift pointer
  seg_t        wr2_q;
  logic [AW-1:0] wr2a_q;
  logic [1:0]  st_q;
  logic [31:0] go_q, gs_q;
  logic        ov_q;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  seg_t        wdata, rdata;

  rff_ram #(.Width(64), .Depth(MAX_SEGMENTS)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [31:0] sat_add(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign grant_offset_o = go_q;
  assign grant_size_o = gs_q;
  assign live_allocations_o = alloc_q;

  // alloc compare on incoming entry
  logic [32:0] len33, max33;
  logic        take, best_lt_max;
  logic [31:0] grant;
  assign len33 = {1'b0, rdata.length};
  assign max33 = {1'b0, b_q};
  assign best_lt_max = $signed(best_q) < $signed(max33);
  assign grant = best_lt_max ? best_q[31:0] : b_q;
  always_comb begin
    if (best_lt_max) take = $signed(len33) > $signed(best_q);
    else take = (len33 >= max33) && ($signed(len33) < $signed(best_q));
  end

  // free adjacency, 33-bit sums so nothing wraps
  logic [32:0] fend, pend;
  logic        mrg_next, mrg_prev;
  assign fend = {1'b0, a_q} + {1'b0, b_q};
  assign pend = {1'b0, pseg_q.start} + {1'b0, pseg_q.length};
  assign mrg_next = (pos_q < cnt_q) && (fend == {1'b0, bseg_q.start});
  assign mrg_prev = pvalid_q && (pend == {1'b0, a_q});

  // combinational ram control
  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = idx_q[AW-1:0];
    case (state_q)
      S_BOOT, S_INIT: begin
        we = 1'b1; waddr = '0; wdata = '{start: 32'd0, length: heap_q};
      end
      S_WR2: begin
        we = 1'b1; waddr = wr2a_q; wdata = wr2_q;
      end
      S_SHDN: begin
        raddr = sh_q[AW-1:0];
        if (rv_q) begin
          we = 1'b1; waddr = AW'(ridx_q - CW'(1)); wdata = rdata;
        end
      end
      S_SHUP: raddr = AW'(sh_q - CW'(1));
      S_SHUPW: begin
        we = 1'b1; waddr = sh_q[AW-1:0]; wdata = rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT; heap_q <= 32'd65536; cnt_q <= CW'(1);
      alloc_q <= '0; ov_q <= 1'b0; rv_q <= 1'b0; idx_q <= '0; ridx_q <= '0;
      cmd_q <= CMD_INIT; a_q <= '0; b_q <= '0; best_q <= '0; found_q <= 1'b0;
      bidx_q <= '0; bseg_q <= '0; pseg_q <= '0; pvalid_q <= 1'b0; pos_q <= '0;
      sh_q <= '0; wr2_q <= '0; wr2a_q <= '0; st_q <= ST_OK;
      go_q <= '0; gs_q <= '0;
    end else begin
      if (state_q == S_DONE) ov_q <= 1'b1;
      else if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        // entry 0 is written this cycle; no result for the reset-time init
        S_BOOT: state_q <= S_IDLE;
        S_IDLE: begin
          if (cfg_valid_i) heap_q <= cfg_data_i;
          if (in_valid_i && !ov_q) begin
            cmd_q <= command_i;
            st_q <= (command_i == CMD_ALLOC && req_min_i > req_max_i) ? ST_NOFIT : ST_OK;
            go_q <= '0; gs_q <= '0;
            idx_q <= '0; rv_q <= 1'b0; found_q <= 1'b0; pvalid_q <= 1'b0;
            case (command_i)
              CMD_INIT: state_q <= S_INIT;
              CMD_ALLOC: begin
                a_q <= req_min_i; b_q <= req_max_i;
                best_q <= {1'b0, req_min_i} - 33'd1;
                state_q <= (req_min_i > req_max_i) ? S_DONE : S_ASCAN;
              end
              CMD_FREE: begin
                a_q <= free_offset_i; b_q <= free_size_i;
                state_q <= (free_size_i == '0) ? S_DONE : S_FSCAN;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_INIT: begin
          cnt_q <= CW'(1); alloc_q <= '0;
          state_q <= S_DONE;
        end
        S_ASCAN: begin
          // issue reads 0..cnt-1, evaluate returned data
          if (idx_q < cnt_q && best_q != max33) begin
            idx_q <= idx_q + CW'(1); rv_q <= 1'b1; ridx_q <= idx_q;
          end else begin
            rv_q <= 1'b0;
            if (!rv_q) state_q <= S_AFIN;
          end
          if (rv_q && best_q != max33 && take) begin
            best_q <= len33; found_q <= 1'b1; bidx_q <= ridx_q[AW-1:0];
            bseg_q <= rdata;
          end
        end
        S_AFIN: begin
          if (!found_q) begin
            st_q <= ST_NOFIT; state_q <= S_DONE;
          end else begin
            go_q <= bseg_q.start;
            gs_q <= grant;
            alloc_q <= alloc_q + 32'd1;
            if (bseg_q.length <= grant) begin
              cnt_q <= cnt_q - CW'(1);
              sh_q <= CW'(bidx_q) + CW'(1); rv_q <= 1'b0;
              state_q <= S_SHDN;
            end else begin
              wr2_q <= '{start: bseg_q.start + grant, length: bseg_q.length - grant};
              wr2a_q <= bidx_q; state_q <= S_WR2;
            end
          end
        end
        S_SHDN: begin
          // move entries [removed+1, old cnt) down by one; cnt_q already reduced
          if (sh_q <= cnt_q) begin
            sh_q <= sh_q + CW'(1); rv_q <= 1'b1; ridx_q <= sh_q;
          end else begin
            rv_q <= 1'b0;
            // a free that joined both neighbors writes the merged entry last
            if (!rv_q) state_q <= (cmd_q == CMD_FREE) ? S_WR2 : S_DONE;
          end
        end
        S_FSCAN: begin
          // find first pos with start >= off
          if (rv_q) begin
            if (rdata.start < a_q) begin
              pseg_q <= rdata; pvalid_q <= 1'b1;
            end else begin
              bseg_q <= rdata; pos_q <= ridx_q; rv_q <= 1'b0;
              state_q <= S_FFIN;
            end
          end
          if (!(rv_q && rdata.start >= a_q)) begin
            if (idx_q < cnt_q) begin
              idx_q <= idx_q + CW'(1); rv_q <= 1'b1; ridx_q <= idx_q;
            end else begin
              rv_q <= 1'b0;
              if (!rv_q || rdata.start < a_q) begin
                pos_q <= cnt_q; state_q <= S_FFIN;
              end
            end
          end
        end
        S_FFIN: begin
          if (mrg_next || mrg_prev || cnt_q < MaxCnt) begin
            if (alloc_q != '0) alloc_q <= alloc_q - 32'd1;
          end
          if (mrg_next && mrg_prev) begin
            wr2_q <= '{start: pseg_q.start,
                       length: sat_add(sat_add(pseg_q.length, b_q), bseg_q.length)};
            wr2a_q <= AW'(pos_q - CW'(1));
            cnt_q <= cnt_q - CW'(1);
            // shift pos+1.. down into pos.., then write the merged entry
            sh_q <= pos_q + CW'(1); rv_q <= 1'b0; state_q <= S_SHDN;
          end else if (mrg_next) begin
            wr2_q <= '{start: a_q, length: sat_add(bseg_q.length, b_q)};
            wr2a_q <= pos_q[AW-1:0]; state_q <= S_WR2;
          end else if (mrg_prev) begin
            wr2_q <= '{start: pseg_q.start, length: sat_add(pseg_q.length, b_q)};
            wr2a_q <= AW'(pos_q - CW'(1)); state_q <= S_WR2;
          end else if (cnt_q >= MaxCnt) begin
            st_q <= ST_FULL; state_q <= S_DONE;
          end else begin
            wr2_q <= '{start: a_q, length: b_q};
            wr2a_q <= pos_q[AW-1:0];
            sh_q <= cnt_q; cnt_q <= cnt_q + CW'(1);
            state_q <= (cnt_q > pos_q) ? S_SHUP : S_WR2;
          end
        end
        S_SHUP: begin
          if (sh_q > pos_q) state_q <= S_SHUPW;
          else state_q <= S_WR2;
        end
        S_SHUPW: begin
          sh_q <= sh_q - CW'(1);
          state_q <= (sh_q - CW'(1) > pos_q) ? S_SHUP : S_WR2;
        end
        S_WR2: state_q <= S_DONE;
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/rff_ram.sv
// rff_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module rff_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

FILE: test/tb.sv
// tb: self-checking bench for range_fit_free_list_allocator_core.
// Depends on rff_pkg and the allocator RTL; the allocator is modeled in the class below.
`timescale 1ns / 1ps

typedef struct packed {
  logic [1:0]  cmd;
  logic [31:0] rmin;
  logic [31:0] rmax;
  logic [31:0] foff;
  logic [31:0] fsize;
} alloc_req_t;

typedef struct packed {
  logic [1:0]  status;
  logic [31:0] goff;
  logic [31:0] gsize;
  logic [31:0] live;
} alloc_rsp_t;

class heap_scoreboard;
  localparam int NSEG = 64;
  logic [31:0] seg_st[NSEG];
  logic [31:0] seg_len[NSEG];
  int          nseg;
  logic [31:0] live_cnt;
  logic [31:0] heap_units;
  alloc_rsp_t  awaiting[$];
  alloc_rsp_t  last;
  int          errors;

  function new();
    heap_units = 32'd65536;
    errors     = 0;
    heap_reset();
  endfunction

  function void heap_reset();
    seg_st[0]  = '0;
    seg_len[0] = heap_units;
    nseg       = 1;
    live_cnt   = '0;
  endfunction

  function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function void drop_seg(int pos);
    for (int i = pos; i + 1 < nseg; i++) begin
      seg_st[i]  = seg_st[i+1];
      seg_len[i] = seg_len[i+1];
    end
    nseg--;
  endfunction

  function logic [1:0] carve(logic [31:0] mn, logic [31:0] mx,
                             output logic [31:0] off, output logic [31:0] sz);
    longint best_sz, want, l;
    int     best;
    bit     hit, take;
    best_sz = longint'(mn) - 1;
    want    = longint'(mx);
    best    = 0;
    hit     = 0;
    off     = '0;
    sz      = '0;
    if (mn > mx) return rff_pkg::ST_NOFIT;
    for (int i = 0; i < nseg && best_sz != want; i++) begin
      l = longint'(seg_len[i]);
      if (best_sz < want) take = l > best_sz;
      else take = want <= l && l < best_sz;
      if (take) begin
        best    = i;
        best_sz = l;
        hit     = 1;
      end
    end
    if (!hit) return rff_pkg::ST_NOFIT;
    sz  = best_sz < want ? best_sz[31:0] : mx;
    off = seg_st[best];
    if (seg_len[best] <= sz) drop_seg(best);
    else begin
      seg_st[best]  += sz;
      seg_len[best] -= sz;
    end
    live_cnt++;
    return rff_pkg::ST_OK;
  endfunction

  function logic [1:0] release_seg(logic [31:0] off, logic [31:0] sz);
    int pos;
    bit join_next, join_prev;
    if (sz == 0) return rff_pkg::ST_OK;
    pos = 0;
    while (pos < nseg && seg_st[pos] < off) pos++;
    // adjacency uses 33-bit sums, no wrap
    join_next = pos < nseg && ({1'b0, off} + {1'b0, sz}) == {1'b0, seg_st[pos]};
    join_prev = pos > 0 &&
                ({1'b0, seg_st[pos-1]} + {1'b0, seg_len[pos-1]}) == {1'b0, off};
    if (join_next && join_prev) begin
      seg_len[pos-1] = sat_sum(sat_sum(seg_len[pos-1], sz), seg_len[pos]);
      drop_seg(pos);
    end else if (join_next) begin
      seg_st[pos]  = off;
      seg_len[pos] = sat_sum(seg_len[pos], sz);
    end else if (join_prev) begin
      seg_len[pos-1] = sat_sum(seg_len[pos-1], sz);
    end else begin
      if (nseg >= NSEG) return rff_pkg::ST_FULL;
      for (int i = nseg; i > pos; i--) begin
        seg_st[i]  = seg_st[i-1];
        seg_len[i] = seg_len[i-1];
      end
      seg_st[pos]  = off;
      seg_len[pos] = sz;
      nseg++;
    end
    if (live_cnt > 0) live_cnt--;
    return rff_pkg::ST_OK;
  endfunction

  function void note_input(alloc_req_t r);
    alloc_rsp_t e;
    e.status = rff_pkg::ST_OK;
    e.goff   = '0;
    e.gsize  = '0;
    case (r.cmd)
      rff_pkg::CMD_INIT:  heap_reset();
      rff_pkg::CMD_ALLOC: e.status = carve(r.rmin, r.rmax, e.goff, e.gsize);
      rff_pkg::CMD_FREE:  e.status = release_seg(r.foff, r.fsize);
      default: ;
    endcase
    e.live = live_cnt;
    last   = e;
    awaiting.push_back(e);
  endfunction

  function void check_result(alloc_rsp_t got);
    alloc_rsp_t e;
    if (awaiting.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result status=%0d", got.status);
      return;
    end
    e = awaiting.pop_front();
    if (got !== e) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: exp st=%0d off=%h size=%h live=%0d, ",
                  "got st=%0d off=%h size=%h live=%0d"},
                 e.status, e.goff, e.gsize, e.live,
                 got.status, got.goff, got.gsize, got.live);
    end
  endfunction
endclass

module tb;
  import rff_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [1:0]  command_i = '0;
  logic [31:0] req_min_i = '0, req_max_i = '0, free_offset_i = '0, free_size_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [1:0]  status_o;
  logic [31:0] grant_offset_o, grant_size_o, live_allocations_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  heap_scoreboard sb = new();
  // grants still outstanding, used to build well-formed frees
  logic [31:0] held_off[$], held_size[$];
  bit          drain_done = 0;

  range_fit_free_list_allocator_core dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // mostly short gaps, some long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one transaction on the request channel; valid stays up between back-to-back items
  task automatic issue(logic [1:0] cmd, logic [31:0] a, logic [31:0] b,
                       logic [31:0] c, logic [31:0] d);
    alloc_req_t r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    r = '{cmd, a, b, c, d};
    in_valid_i    <= 1;
    command_i     <= cmd;
    req_min_i     <= a;
    req_max_i     <= b;
    free_offset_i <= c;
    free_size_i   <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(r);
    if (cmd == CMD_INIT) begin
      held_off.delete();
      held_size.delete();
    end else if (cmd == CMD_ALLOC && sb.last.status == ST_OK && sb.last.gsize != 0) begin
      held_off.push_back(sb.last.goff);
      held_size.push_back(sb.last.gsize);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.awaiting.size() != 0) @(posedge clk_i);
  endtask

  // heap_size may only change with nothing in flight
  task automatic set_heap(logic [31:0] units);
    wait_idle();
    cfg_valid_i <= 1;
    cfg_data_i  <= units;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.heap_units = units;
    cfg_valid_i <= 0;
  endtask

  // random traffic: mostly allocs sized to the heap and frees of real grants
  task automatic random_phase(int n, logic [31:0] heap);
    longint lim;
    logic [31:0] mn, mx;
    int k, r;
    lim = heap > 2000 ? longint'(heap) / 16 : longint'(heap);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 42) begin
        mn = $urandom_range(0, 7) == 0 ? $urandom() : 32'($urandom_range(0, int'(lim / 2)));
        mx = $urandom_range(0, 9) == 0 ? $urandom() : mn + 32'($urandom_range(0, int'(lim)));
        if ($urandom_range(0, 15) == 0) mx = mn - 1;
        issue(CMD_ALLOC, mn, mx, $urandom(), $urandom());
      end else if (r < 82 && held_off.size() > 0) begin
        k = $urandom_range(0, held_off.size() - 1);
        issue(CMD_FREE, $urandom(), $urandom(), held_off[k], held_size[k]);
        held_off.delete(k);
        held_size.delete(k);
      end else if (r < 92) begin
        issue(CMD_FREE, $urandom(), $urandom(), $urandom(),
              $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 64)));
      end else if (r < 96) begin
        issue(CMD_INIT, $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        issue(CMD_NONE, $urandom(), $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  // result side: stretches of no stall, random stalls, and stalls of random length
  initial begin
    int mode, gap;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 200)) begin
        @(posedge clk_i);
        if (mode == 2) begin
          gap = pick_gap();
          if (gap > 0) begin
            out_ready_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          out_ready_i <= 1'b1;
        end else out_ready_i <= mode == 0 ? 1'b1 : pick_gap() == 0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{status_o, grant_offset_o, grant_size_o, live_allocations_o});
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: zero grant, min above max, empty table, merges, edge frees
    issue(CMD_NONE, '1, '1, '1, '1);
    issue(CMD_FREE, 0, 0, 32'h1234, 0);
    issue(CMD_ALLOC, 0, 0, 0, 0);
    issue(CMD_ALLOC, 5, 4, 0, 0);
    issue(CMD_ALLOC, '1, '1, 0, 0);
    issue(CMD_ALLOC, 1, '1, 0, 0);
    issue(CMD_ALLOC, 0, 10, 0, 0);
    issue(CMD_FREE, 0, 0, 0, 100);
    issue(CMD_FREE, 0, 0, 200, 50);
    issue(CMD_FREE, 0, 0, 100, 100);
    issue(CMD_FREE, 0, 0, 300, 10);
    issue(CMD_ALLOC, 20, 60, 0, 0);
    issue(CMD_ALLOC, 0, 5, 0, 0);
    issue(CMD_FREE, 0, 0, 32'hFFFF_FFF0, '1);
    issue(CMD_FREE, 0, 0, 32'hFFFF_FFE0, 32'h10);
    issue(CMD_INIT, 0, 0, 0, 0);
    issue(CMD_FREE, 0, 0, 32'h10000, '1);
    issue(CMD_ALLOC, '1, '1, 0, 0);
    issue(CMD_ALLOC, 0, '1, 0, 0);
    issue(CMD_ALLOC, 0, 0, 0, 0);

    // sender holds off until everything is back
    wait_idle();
    random_phase(150, 32'd65536);

    set_heap(32'd1);
    issue(CMD_INIT, 0, 0, 0, 0);
    random_phase(60, 32'd1);

    set_heap(32'hFFFF_FFFF);
    issue(CMD_INIT, 0, 0, 0, 0);
    issue(CMD_FREE, 0, 0, 0, 32'h10);
    random_phase(170, 32'hFFFF_FFFF);

    // fill the table with isolated segments until the free is refused
    set_heap(32'd300);
    issue(CMD_INIT, 0, 0, 0, 0);
    for (int k = 0; k < 66; k++) issue(CMD_FREE, 0, 0, 32'd1000 + 32'(3 * k), 1);
    issue(CMD_FREE, 0, 0, 32'd999, 1);
    issue(CMD_ALLOC, 1, 1, 0, 0);
    issue(CMD_FREE, 0, 0, 32'd5000, 7);
    random_phase(200, 32'd300);

    set_heap(32'd5000);
    issue(CMD_INIT, 0, 0, 0, 0);
    random_phase(270, 32'd5000);

    wait_idle();
    repeat (250) @(posedge clk_i);
    drain_done = 1;
    if (sb.errors == 0 && sb.awaiting.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #20ms;
    if (!drain_done) begin
      $display("tb: errors");
      $finish;
    end
  end
endmodule

FILE: range_fit_free_list_allocator_core.f
sv/rff_pkg.sv
sv/rff_ram.sv
sv/range_fit_free_list_allocator_core.sv
test/tb.sv
